### rtl/rwp_pkg.sv
// ----------------------------------------------------------------------------
// rwp_pkg
// Shared types and constants for the RGB10 word to packed byte stream block.
// ----------------------------------------------------------------------------
package rwp_pkg;

	localparam int ACC_W    = 40;  // held bits plus one pixel, padded to whole bytes
	localparam int HELD_W   = 7;
	localparam int HCNT_W   = 3;
	localparam int TOTAL_W  = 6;
	localparam int NB_W     = 3;   // 1..5 bytes per item
	localparam int RGB_W    = 30;
	localparam int GRAY_W   = 8;
	localparam int Q_DEPTH  = 4;
	localparam int Q_PTR_W  = $clog2(Q_DEPTH);
	localparam int Q_CNT_W  = $clog2(Q_DEPTH + 1);

	localparam logic MODE_RGB10 = 1'b0;
	localparam logic MODE_GRAY8 = 1'b1;

	localparam logic REG_COLOR_MODE = 1'b0;  // register index, from paddr[2]

	typedef struct packed {
		logic [ACC_W-1:0] bits;     // left-aligned, first byte in the top bits
		logic [NB_W-1:0]  nbytes;
		logic             row_end;
	} rwp_entry_t;

endpackage

### rtl/rwp_front.sv
// ----------------------------------------------------------------------------
// rwp_front
// Merges held bits with the incoming pixel, pads at row end, counts output
// bytes and keeps the leftover bits for the next pixel.
// ----------------------------------------------------------------------------
module rwp_front import rwp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        color_mode,
	input  logic        take,
	input  logic [31:0] raw_word,
	input  logic        row_end,
	output rwp_entry_t  entry
);

	logic [HELD_W-1:0]  held_bits_q;
	logic [HCNT_W-1:0]  held_count_q;

	logic [HELD_W-1:0]  held_left;
	logic [ACC_W-1:0]   data_part;
	logic [ACC_W-1:0]   acc;
	logic [TOTAL_W-1:0] total;
	logic [TOTAL_W-1:0] total_rnd;
	logic [NB_W-1:0]    nbytes;
	logic [HCNT_W-1:0]  next_count;
	logic [ACC_W-1:0]   rest;
	logic [HELD_W-1:0]  next_bits;

	always_comb begin
		held_left = held_bits_q << (3'd7 - held_count_q);
		if (color_mode == MODE_RGB10) begin
			data_part = {raw_word[RGB_W-1:0], 10'b0} >> held_count_q;
			total     = TOTAL_W'(held_count_q) + TOTAL_W'(RGB_W);
		end else begin
			data_part = {raw_word[GRAY_W-1:0], 32'b0} >> held_count_q;
			total     = TOTAL_W'(held_count_q) + TOTAL_W'(GRAY_W);
		end
		acc = {held_left, 33'b0} | data_part;
		// row end rounds up to a byte boundary; padding bits are already zero
		total_rnd  = total + TOTAL_W'(7);
		nbytes     = row_end ? total_rnd[5:3] : total[5:3];
		next_count = row_end ? '0 : total[2:0];
		rest       = acc << {nbytes, 3'b000};
		next_bits  = rest[ACC_W-1 -: HELD_W] >> (3'd7 - next_count);

		entry.bits    = acc;
		entry.nbytes  = nbytes;
		entry.row_end = row_end;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_bits_q  <= '0;
			held_count_q <= '0;
		end else if (take) begin
			held_bits_q  <= next_bits;
			held_count_q <= next_count;
		end
	end

endmodule

### rtl/rwp_fifo.sv
// ----------------------------------------------------------------------------
// rwp_fifo
// Short queue of packed items between the front and the byte emitter.
// ----------------------------------------------------------------------------
module rwp_fifo import rwp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  rwp_entry_t wr_entry,
	input  logic       pop,
	output rwp_entry_t head,
	output logic       full,
	output logic       empty
);

	rwp_entry_t         mem_q [Q_DEPTH];
	logic [Q_PTR_W-1:0] wr_ptr_q;
	logic [Q_PTR_W-1:0] rd_ptr_q;
	logic [Q_CNT_W-1:0] count_q;

	assign full  = (count_q == Q_CNT_W'(Q_DEPTH));
	assign empty = (count_q == '0);
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

### rtl/rwp_back.sv
// ----------------------------------------------------------------------------
// rwp_back
// Walks the head item into the output register one byte per cycle while m_tready does not stall it.
// ----------------------------------------------------------------------------
module rwp_back import rwp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  rwp_entry_t head,
	input  logic       empty,
	output logic       pop,
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // out_byte[7:0]
	output logic       m_tlast,   // row_done
	output logic       m_tuser    // last_of_item
);

	logic            valid_q;
	logic [7:0]      byte_q;
	logic            last_q;
	logic            row_q;
	logic [NB_W-1:0] idx_q;

	logic             load;
	logic             final_byte;
	logic [ACC_W-1:0] shifted;

	always_comb begin
		load       = !valid_q || m_tready;
		final_byte = (idx_q == head.nbytes - 1'b1);
		pop        = load && !empty && final_byte;
		shifted    = head.bits << {idx_q, 3'b000};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= '0;
		end else if (load) begin
			valid_q <= !empty;
			if (!empty) idx_q <= final_byte ? '0 : idx_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (load && !empty) begin
			byte_q <= shifted[ACC_W-1 -: 8];
			last_q <= final_byte;
			row_q  <= final_byte && head.row_end;
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = byte_q;
	assign m_tuser  = last_q;
	assign m_tlast  = row_q;

endmodule

### rtl/rgb10_word_to_packed_bytes.sv
// ----------------------------------------------------------------------------
// rgb10_word_to_packed_bytes
// Packs 10-bit RGB pixel words (or gray bytes) MSB first into a byte stream,
// zero padding each row to a byte boundary.
// ----------------------------------------------------------------------------
//  channel  | dir | payload                               | handshake
//  s_axis   | in  | tdata=raw_word[31:0], tlast=row_end   | s_tvalid/s_tready
//  m_axis   | out | tdata=out_byte, tuser=last_of_item,   | m_tvalid/m_tready
//           |     | tlast=row_done                        |
//  apb      | in  | reg 0 @0x0: color_mode (bit 0)        | psel/penable
//
// A pixel is accepted whenever the 4-entry queue has room. Output runs one
// byte per cycle while m_tready does not stall it: an RGB pixel gives 3 to 5
// bytes, a gray pixel 1 or 2; the byte emitter sets the sustained rate. After
// acceptance an item is written into the queue, then loaded byte by byte into
// the output register. Reset clears held bits, queue and output register.
// Output stalls back up through the queue only.
module rgb10_word_to_packed_bytes import rwp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // raw_word[31:0]
	input  logic        s_tlast,   // row_end
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // out_byte[7:0]
	output logic        m_tlast,   // row_done
	output logic        m_tuser,   // last_of_item
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic       color_mode_q;
	logic       take;
	logic       full;
	logic       empty;
	logic       pop;
	rwp_entry_t entry;
	rwp_entry_t head;

	assign pready   = 1'b1;
	assign s_tready = !full;
	assign take     = s_tvalid && !full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			color_mode_q <= MODE_RGB10;
		end else if (psel && penable && pwrite && pready && paddr[2] == REG_COLOR_MODE) begin
			color_mode_q <= pwdata[0];
		end
	end

	assign prdata = (paddr[2] == REG_COLOR_MODE) ? {31'b0, color_mode_q} : '0;

	rwp_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.color_mode (color_mode_q),
		.take       (take),
		.raw_word   (s_tdata),
		.row_end    (s_tlast),
		.entry      (entry)
	);

	rwp_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (take),
		.wr_entry (entry),
		.pop      (pop),
		.head     (head),
		.full     (full),
		.empty    (empty)
	);

	rwp_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (head),
		.empty    (empty),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

endmodule

### verif/rwp_byte_stream_checker.sv
// ----------------------------------------------------------------------------
// rwp_byte_stream_checker
// Watches the pixel, byte and register channels of the RGB10 byte packer,
// predicts every packed byte from the accepted pixels and the current color
// mode, and compares each output transaction in order against that prediction.
// ----------------------------------------------------------------------------
module rwp_byte_stream_checker import rwp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [31:0] s_tdata,   // raw_word[31:0]
	input  logic        s_tlast,   // row_end
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [7:0]  m_tdata,   // out_byte[7:0]
	input  logic        m_tlast,   // row_done
	input  logic        m_tuser,   // last_of_item
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	input  logic [31:0] prdata,
	input  logic        pready,
	output int          pending,
	output int          fail_count
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       last_of_item;
		logic       row_done;
	} packed_byte_t;

	packed_byte_t expected_bytes[$];
	logic         color_mode;
	logic [6:0]   held_bits;
	int           held_count;
	int           errs;

	// Appends one pixel to the bit accumulator and queues every whole byte.
	task automatic pack_pixel(input logic [31:0] word, input logic row_end);
		logic [39:0]  acc;
		int           total;
		int           pad;
		packed_byte_t b;
		acc   = 40'(held_bits & 7'((1 << held_count) - 1));
		total = held_count;
		if (color_mode == MODE_RGB10) begin
			acc   = (acc << 30) | 40'({word[29:20], word[19:10], word[9:0]});
			total = total + 30;
		end else begin
			acc   = (acc << 8) | 40'(word[7:0]);
			total = total + 8;
		end
		if (row_end && (total % 8) != 0) begin
			pad   = 8 - (total % 8);
			acc   = acc << pad;
			total = total + pad;
		end
		while (total >= 8) begin
			b.out_byte     = acc[total-1 -: 8];
			total          = total - 8;
			b.last_of_item = (total < 8);
			b.row_done     = (total < 8) && row_end;
			expected_bytes.push_back(b);
		end
		held_count = total;
		held_bits  = acc[6:0] & 7'((1 << total) - 1);
	endtask

	always @(posedge clk or negedge arst_n) begin
		packed_byte_t want;
		if (!arst_n) begin
			expected_bytes.delete();
			color_mode = MODE_RGB10;
			held_bits  = '0;
			held_count = 0;
			errs       = 0;
			pending    <= 0;
			fail_count <= 0;
		end else begin
			if (psel && penable && pready) begin
				if (pwrite) begin
					if (paddr[2] == REG_COLOR_MODE)
						color_mode = pwdata[0];
				end else if (paddr[2] == REG_COLOR_MODE && prdata !== {31'b0, color_mode}) begin
					$error("color_mode: expected %08h, got %08h", {31'b0, color_mode}, prdata);
					errs++;
				end
			end
			if (m_tvalid && m_tready) begin
				if (expected_bytes.size() == 0) begin
					$error("unexpected output transaction: out_byte %02h", m_tdata);
					errs++;
				end else begin
					want = expected_bytes.pop_front();
					if (m_tdata !== want.out_byte) begin
						$error("out_byte: expected %02h, got %02h", want.out_byte, m_tdata);
						errs++;
					end
					if (m_tuser !== want.last_of_item) begin
						$error("last_of_item: expected %0b, got %0b", want.last_of_item, m_tuser);
						errs++;
					end
					if (m_tlast !== want.row_done) begin
						$error("row_done: expected %0b, got %0b", want.row_done, m_tlast);
						errs++;
					end
				end
			end
			// first byte of a pixel trails its acceptance, so pop before push
			if (s_tvalid && s_tready)
				pack_pixel(s_tdata, s_tlast);
			pending    <= expected_bytes.size();
			fail_count <= errs;
		end
	end

endmodule

### verif/tb_rgb10_word_to_packed_bytes.sv
// ----------------------------------------------------------------------------
// tb_rgb10_word_to_packed_bytes
// Drives pixels with random bursts and gaps, stalls the byte side on shifting
// patterns, and switches the color mode between phases, including mid-row.
// ----------------------------------------------------------------------------
module tb_rgb10_word_to_packed_bytes;
	import rwp_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int         CYCLE_LIMIT     = 300000;
	localparam int         PHASE_ITEMS     = 85;
	localparam logic [2:0] ADDR_COLOR_MODE = {REG_COLOR_MODE, 2'b00};
	localparam logic [2:0] ADDR_UNMAPPED   = {~REG_COLOR_MODE, 2'b00};

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [31:0] s_tdata;   // raw_word[31:0]
	logic        s_tlast;   // row_end
	logic        m_tvalid;
	logic        m_tready;
	logic [7:0]  m_tdata;   // out_byte[7:0]
	logic        m_tlast;   // row_done
	logic        m_tuser;   // last_of_item
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	int pending;
	int fail_count;
	int cycle_count;
	int burst_left;

	rgb10_word_to_packed_bytes dut (.*);

	rwp_byte_stream_checker checker_i (.*);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// byte side: switches among free-running, random, sparse and light stalls
	initial begin
		int style;
		int style_left;
		int tick;
		style      = 0;
		style_left = 0;
		tick       = 0;
		m_tready   <= 1'b0;
		forever begin
			@(posedge clk);
			if (style_left == 0) begin
				style      = $urandom_range(0, 3);
				style_left = $urandom_range(20, 80);
			end
			style_left--;
			tick++;
			case (style)
				0: m_tready <= 1'b1;
				1: m_tready <= 1'($urandom_range(0, 1));
				2: m_tready <= (tick % 4 == 0);
				default: m_tready <= ($urandom_range(0, 9) != 0);
			endcase
		end
	end

	function automatic logic [31:0] rand_word();
		case ($urandom_range(0, 9))
			0: return 32'h0000_0000;
			1: return 32'hffff_ffff;
			default: return $urandom();
		endcase
	endfunction

	// One pixel transaction; valid stays up while the burst lasts.
	task automatic send_pixel(input logic [31:0] word, input logic row_end);
		s_tdata  <= word;
		s_tlast  <= row_end;
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60)
				: $urandom_range(0, 12);
		end
	endtask

	// Holds the pixel side until every predicted byte has left the block.
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	task automatic apb_access(input logic wr, input logic [2:0] addr, input logic [31:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= addr;
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic set_mode(input logic mode);
		apb_access(1'b1, ADDR_COLOR_MODE, ($urandom() & 32'hffff_fffe) | 32'(mode));
		apb_access(1'b0, ADDR_COLOR_MODE, 32'h0);
	endtask

	initial begin
		int   sent;
		int   row_len;
		logic phase_mode;
		s_tvalid    <= 1'b0;
		s_tdata     <= '0;
		s_tlast     <= 1'b0;
		psel        <= 1'b0;
		penable     <= 1'b0;
		pwrite      <= 1'b0;
		paddr       <= '0;
		pwdata      <= '0;
		arst_n      <= 1'b0;
		cycle_count <= 0;
		burst_left  = 4;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// RGB after reset: extremes, ignored top bits, carry across pixels
		apb_access(1'b0, ADDR_COLOR_MODE, 32'h0);
		send_pixel(32'h0000_0000, 1'b0);
		send_pixel(32'hffff_ffff, 1'b1);
		send_pixel(32'h3fff_ffff, 1'b1);
		send_pixel(32'hc000_0000, 1'b1);
		send_pixel(32'h2aaa_aaaa, 1'b0);
		send_pixel(32'h1555_5555, 1'b0);
		send_pixel(32'h1234_5678, 1'b0);
		send_pixel(32'h3ff0_03ff, 1'b1);
		// leave bits held, then switch to gray in mid-row
		send_pixel(32'h0abc_def1, 1'b0);
		wait_drained();
		apb_access(1'b1, ADDR_COLOR_MODE, 32'hffff_ffff);
		apb_access(1'b0, ADDR_COLOR_MODE, 32'h0);
		send_pixel(32'hffff_ff5a, 1'b0);
		send_pixel(32'h0000_00a5, 1'b1);
		// gray with nothing held passes bytes straight through
		send_pixel(32'h0000_0000, 1'b1);
		send_pixel(32'h1234_56ff, 1'b0);
		send_pixel(32'hffff_ff80, 1'b1);
		wait_drained();
		// unmapped register index must leave the mode alone
		apb_access(1'b1, ADDR_UNMAPPED, 32'h0);
		apb_access(1'b0, ADDR_COLOR_MODE, 32'h0);
		send_pixel(32'h0000_0001, 1'b1);
		wait_drained();
		apb_access(1'b1, ADDR_COLOR_MODE, 32'hffff_fffe);
		apb_access(1'b0, ADDR_COLOR_MODE, 32'h0);
		send_pixel(32'h3ff0_0000, 1'b0);
		send_pixel(32'h000f_fc00, 1'b1);

		// random rows; a phase may stop in mid-row before the next mode write
		for (int ph = 0; ph < 6; ph++) begin
			wait_drained();
			phase_mode = (ph == 1 || ph == 4) ? MODE_GRAY8
				: ((ph == 5) ? 1'($urandom_range(0, 1)) : MODE_RGB10);
			set_mode(phase_mode);
			sent = 0;
			while (sent < PHASE_ITEMS) begin
				row_len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 50)
					: $urandom_range(1, 8);
				for (int i = 0; i < row_len && sent < PHASE_ITEMS; i++) begin
					if (ph == 2 && sent == 40)
						wait_drained();
					send_pixel(rand_word(), (i == row_len - 1) || ($urandom_range(0, 19) == 0));
					sent++;
				end
			end
		end

		wait_drained();
		repeat (20) @(posedge clk);
		if (fail_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
